// ===== rtl/plbfrd_pkg.sv =====
// Package for the packed low-bit four-row dot product block.
// Holds field widths, the weight mode codes and the weight slot decoder.
// No dependencies.
`default_nettype none

package plbfrd_pkg;

  localparam int unsigned LANES     = 4;   // element slots per word
  localparam int unsigned VEC_W     = 32;  // vector field width
  localparam int unsigned ROW_W     = 32;  // packed weight field width per row
  localparam int unsigned CNT_W     = 3;   // valid count field width
  localparam int unsigned ELEM_W    = 8;   // vector element width
  localparam int unsigned PROD_W    = 16;  // signed 8 x 8 product
  localparam int unsigned GRP_SUM_W = 18;  // sum of four products
  localparam int unsigned SUM_W     = 32;  // result field width per row

  typedef enum logic [1:0] {
    WMODE_INT8 = 2'd0,
    WMODE_INT4 = 2'd1,
    WMODE_INT2 = 2'd2
  } weight_mode_e;

  // Sign-extended weight of one slot; the unused mode code falls back to 8 bit
  function automatic logic signed [ELEM_W-1:0] weight_elem(
    input logic [ROW_W-1:0] bits,
    input weight_mode_e     mode,
    input logic [1:0]       lane
  );
    logic [7:0] byt;
    logic [3:0] nib;
    logic [1:0] crumb;
    byt   = bits[lane*8 +: 8];
    nib   = bits[lane*4 +: 4];
    crumb = bits[lane*2 +: 2];
    case (mode)
      WMODE_INT4: weight_elem = {{4{nib[3]}}, nib};
      WMODE_INT2: weight_elem = {{6{crumb[1]}}, crumb};
      default:    weight_elem = byt;
    endcase
  endfunction

endpackage

`default_nettype wire

// ===== rtl/packed_low_bit_four_row_dot.sv =====
// Top level of the packed low-bit four-row dot product block.
// Depends on plbfrd_pkg (widths, weight mode codes, slot decoder).
//
// Computes ROWS signed dot products of packed weight rows (8, 4 or 2 bit
// signed, chosen by weight_mode) against a shared vector of signed bytes.
// Each input word brings four vector elements and four weights per row; the
// lowest valid_count slots (counts above four act as four) are multiplied and
// added into per-row ACC_WIDTH-bit accumulators that wrap. A word with tlast
// set emits one output word with the low 32 bits of every sum, that word
// included, and clears the accumulators. Throughput is one word per clock
// while s_axis_tready is high: a taken word is loaded into the input
// register; from there four 8x8 multiplies per row, a four-input adder per
// row and the accumulator add finish into the accumulators and, for a last
// word, the result register, which offers the result word. A non-last word
// never waits in the input register; a last word waits there only while
// the result register holds an unread word, and only then is s_axis_tready
// low.
// weight_mode may be written only while no word is in flight.
`default_nettype none

module packed_low_bit_four_row_dot
  import plbfrd_pkg::*;
#(
  parameter int unsigned ROWS      = 4,
  parameter int unsigned ACC_WIDTH = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // config: weight_mode
  input  wire logic                 cfg_we_i,
  input  wire logic [1:0]           cfg_wdata_i,
  // input words
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  // tdata: vector_word, row0_bits .. row(ROWS-1)_bits, valid_count, zero pad
  input  wire logic [((VEC_W + ROWS*ROW_W + CNT_W + 7) / 8) * 8 - 1:0] s_axis_tdata,
  input  wire logic                 s_axis_tlast,   // last_group
  // result words
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // tdata: sum_row0 .. sum_row(ROWS-1), 32 bits each
  output logic [ROWS*SUM_W-1:0]     m_axis_tdata
);

  localparam int unsigned WIDE_W = (ACC_WIDTH > SUM_W) ? ACC_WIDTH : SUM_W;

  // configuration
  weight_mode_e mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= WMODE_INT8;
    end else if (cfg_we_i) begin
      mode_q <= weight_mode_e'(cfg_wdata_i);
    end
  end

  // input register
  logic             in_valid_q, in_valid_d;
  logic [VEC_W-1:0] in_vec_q;
  logic [ROW_W-1:0] in_rows_q [ROWS];
  logic [CNT_W-1:0] in_cnt_q;
  logic             in_last_q;
  logic             s_accept;
  logic             advance;

  // result register and accumulators
  logic                 out_valid_q, out_valid_d;
  logic [SUM_W-1:0]     out_sum_q [ROWS];
  logic [ACC_WIDTH-1:0] acc_q [ROWS];
  logic [ACC_WIDTH-1:0] acc_new [ROWS];

  // handshake: the input stage drains unless a last word meets an unread result word
  always_comb begin
    advance       = in_valid_q && (!in_last_q || !out_valid_q || m_axis_tready);
    s_axis_tready = !in_valid_q || advance;
    s_accept      = s_axis_tvalid && s_axis_tready;

    in_valid_d = in_valid_q;
    if (s_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end

    out_valid_d = out_valid_q;
    if (advance && in_last_q) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_vec_q  <= s_axis_tdata[VEC_W-1:0];
      in_cnt_q  <= s_axis_tdata[VEC_W + ROWS*ROW_W +: CNT_W];
      in_last_q <= s_axis_tlast;
      for (int r = 0; r < ROWS; r++) begin
        in_rows_q[r] <= s_axis_tdata[VEC_W + r*ROW_W +: ROW_W];
      end
    end
  end

  // multiply and add: per row, four lane products summed into the accumulator
  always_comb begin
    logic                        lane_en;
    logic signed [ELEM_W-1:0]    xv;
    logic signed [ELEM_W-1:0]    wv;
    logic signed [PROD_W-1:0]    prod;
    logic signed [GRP_SUM_W-1:0] grp;
    for (int r = 0; r < ROWS; r++) begin
      grp = '0;
      for (int j = 0; j < LANES; j++) begin
        lane_en = in_cnt_q > CNT_W'(j);  // counts above four cover all lanes
        xv      = in_vec_q[j*ELEM_W +: ELEM_W];
        wv      = weight_elem(in_rows_q[r], mode_q, 2'(j));
        prod    = xv * wv;
        if (lane_en) begin
          grp = grp + GRP_SUM_W'(prod);
        end
      end
      acc_new[r] = acc_q[r] + {{(ACC_WIDTH - GRP_SUM_W){grp[GRP_SUM_W-1]}}, grp};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < ROWS; r++) begin
        acc_q[r] <= '0;
      end
    end else if (advance) begin
      for (int r = 0; r < ROWS; r++) begin
        acc_q[r] <= in_last_q ? '0 : acc_new[r];
      end
    end
  end

  // result: low 32 bits of the wrapped sum, zero-extended for narrow accumulators
  always_ff @(posedge clk_i) begin
    logic [WIDE_W-1:0] wide;
    if (advance && in_last_q) begin
      for (int r = 0; r < ROWS; r++) begin
        wide         = WIDE_W'(acc_new[r]);
        out_sum_q[r] <= wide[SUM_W-1:0];
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;

  always_comb begin
    for (int r = 0; r < ROWS; r++) begin
      m_axis_tdata[r*SUM_W +: SUM_W] = out_sum_q[r];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/plbfrd_checker.sv =====
// Port-level checker for the packed low-bit four-row dot product block.
// Bound to packed_low_bit_four_row_dot; depends on plbfrd_pkg for widths.
`default_nettype none

module plbfrd_checker
  import plbfrd_pkg::*;
#(
  parameter int unsigned ROWS = 4
) (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 s_axis_tvalid,
  input wire logic                 s_axis_tready,
  input wire logic                 s_axis_tlast,
  input wire logic                 m_axis_tvalid,
  input wire logic                 m_axis_tready,
  input wire logic [ROWS*SUM_W-1:0] m_axis_tdata
);

  // a held result word stays offered
  a_out_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result word withdrawn while stalled");

  // a held result word keeps its sums
  a_out_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result sums changed while stalled");

  // input side only stalls behind an unread result word
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid || m_axis_tready |-> s_axis_tready)
    else $error("input stalled with free result register");

  // a new result word follows a taken last input word
  a_out_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tlast, 2))
    else $error("result word without a last input word");

endmodule

bind packed_low_bit_four_row_dot plbfrd_checker #(
  .ROWS(ROWS)
) u_plbfrd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tlast (s_axis_tlast),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

`default_nettype wire

// ===== verif/dot_sum_checker.sv =====
// Scoreboard for the packed low-bit four-row dot product block.
// Watches the config port and both stream channels, predicts the row sums
// and compares them with the output words. Depends on plbfrd_pkg.

module dot_sum_checker
  import plbfrd_pkg::*;
#(
  parameter int unsigned ROWS = 4,
  parameter int unsigned IN_W = ((VEC_W + ROWS*ROW_W + CNT_W + 7) / 8) * 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_wdata_i,
  input  logic                       s_tvalid_i,
  input  logic                       s_tready_i,
  input  logic [IN_W-1:0]            s_tdata_i,
  input  logic                       s_tlast_i,
  input  logic                       m_tvalid_i,
  input  logic                       m_tready_i,
  input  logic [ROWS*SUM_W-1:0]      m_tdata_i,
  output int                         errors_o,
  output int                         pending_o
);

  typedef logic [ROWS-1:0][SUM_W-1:0] row_sums_t;

  logic [1:0]       mode_q;
  logic [SUM_W-1:0] row_acc [ROWS];
  row_sums_t        sums_awaited [$];
  int               err_cnt;

  // Dot product of one packed weight row with the vector, valid slots only
  function automatic logic [SUM_W-1:0] group_dot(
    input logic [ROW_W-1:0] wbits,
    input logic [VEC_W-1:0] vec,
    input logic [1:0]       mode,
    input logic [CNT_W-1:0] cnt
  );
    int                       n;
    logic signed [7:0]        x;
    logic signed [7:0]        w;
    logic signed [3:0]        nib;
    logic signed [1:0]        crumb;
    logic signed [15:0]       prod;
    logic signed [SUM_W-1:0]  s;
    n = (cnt > LANES) ? LANES : int'(cnt);
    s = '0;
    for (int j = 0; j < n; j++) begin
      x     = vec[8*j +: 8];
      nib   = wbits[4*j +: 4];
      crumb = wbits[2*j +: 2];
      case (mode)
        WMODE_INT4: w = nib;
        WMODE_INT2: w = crumb;
        default:    w = wbits[8*j +: 8];  // spare code acts as 8 bit
      endcase
      prod = x * w;
      s    = s + prod;
    end
    return s;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    row_sums_t got;
    row_sums_t want;
    if (!rst_ni) begin
      mode_q = WMODE_INT8;
      for (int r = 0; r < ROWS; r++) row_acc[r] = '0;
      sums_awaited.delete();
      err_cnt   = 0;
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        got = m_tdata_i;
        if (sums_awaited.size() == 0) begin
          err_cnt++;
          $display("%0t: sums word with none awaited, expected none, actual %h",
                   $time, got);
        end else begin
          want = sums_awaited.pop_front();
          for (int r = 0; r < ROWS; r++) begin
            if (got[r] !== want[r]) begin
              err_cnt++;
              $display("%0t: sum_row%0d expected %0d actual %0d", $time, r,
                       $signed(want[r]), $signed(got[r]));
            end
          end
        end
      end

      if (cfg_we_i) mode_q = cfg_wdata_i;

      if (s_tvalid_i && s_tready_i) begin
        for (int r = 0; r < ROWS; r++) begin
          row_acc[r] = row_acc[r] + group_dot(s_tdata_i[VEC_W + r*ROW_W +: ROW_W],
                                              s_tdata_i[0 +: VEC_W], mode_q,
                                              s_tdata_i[VEC_W + ROWS*ROW_W +: CNT_W]);
        end
        if (s_tlast_i) begin
          for (int r = 0; r < ROWS; r++) begin
            want[r]    = row_acc[r];
            row_acc[r] = '0;
          end
          sums_awaited.push_back(want);
        end
      end

      errors_o  <= err_cnt;
      pending_o <= sums_awaited.size();
    end
  end

endmodule

// ===== verif/tb_top.sv =====
// Top of the testbench for packed_low_bit_four_row_dot.
// Drives config writes and input words, applies output back-pressure and
// gives the verdict; sum checking lives in dot_sum_checker. Depends on plbfrd_pkg.

module tb_top;
  import plbfrd_pkg::*;

  localparam int unsigned ROWS           = 4;
  localparam int unsigned IN_W           = ((VEC_W + ROWS*ROW_W + CNT_W + 7) / 8) * 8;
  localparam int unsigned PAD_W          = IN_W - (VEC_W + ROWS*ROW_W + CNT_W);
  localparam int unsigned RANDOM_WORDS   = 900;
  localparam int unsigned PHASES         = 6;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  // settle wait after the sums are drained, with margin
  localparam int unsigned SETTLE_CYCLES  = 4;

  // weight_mode code with no meaning of its own, decodes as 8 bit
  localparam logic [1:0] WMODE_SPARE = 2'd3;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [1:0]            cfg_wdata_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  // tdata: vector_word, row0_bits, row1_bits, row2_bits, row3_bits, valid_count, pad
  logic [IN_W-1:0]       s_axis_tdata;
  logic                  s_axis_tlast;   // last_group
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  // tdata: sum_row0, sum_row1, sum_row2, sum_row3
  logic [ROWS*SUM_W-1:0] m_axis_tdata;

  int sum_errors;
  int sums_pending;
  int quiet_cycles = 0;
  bit idle_en;      // random gaps on both sides while set

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  packed_low_bit_four_row_dot #(
    .ROWS      (ROWS),
    .ACC_WIDTH (32)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  dot_sum_checker #(
    .ROWS (ROWS),
    .IN_W (IN_W)
  ) sums_chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_i (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .s_tlast_i  (s_axis_tlast),
    .m_tvalid_i (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_i  (m_axis_tdata),
    .errors_o   (sum_errors),
    .pending_o  (sums_pending)
  );

  // Receiver: random stall bursts while idling is on
  always begin
    @(posedge clk_i);
    if (idle_en && rst_ni && $urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      m_axis_tready <= 1'b1;
    end
  end

  // Watchdog: too long with no word moving on any port ends the run
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Weight or vector word, biased towards extremes and sign patterns
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 11))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8080_8080;
      3:       return 32'h7F7F_7F7F;
      4:       return 32'h8888_8888;
      5:       return 32'h7777_7777;
      6:       return 32'hAAAA_AAAA;
      7:       return 32'h5555_5555;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [CNT_W-1:0] pick_count();
    if ($urandom_range(0, 9) < 7) return CNT_W'(LANES);
    return CNT_W'($urandom_range(0, 7));
  endfunction

  // Present one word, optionally after a gap, and hold it until taken.
  // Called on a rising edge; returns on the edge that accepted the word.
  task automatic push_word(
    input logic [31:0]      vec,
    input logic [31:0]      r0,
    input logic [31:0]      r1,
    input logic [31:0]      r2,
    input logic [31:0]      r3,
    input logic [CNT_W-1:0] cnt,
    input logic             last
  );
    if (idle_en && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{PAD_W{1'b0}}, cnt, r3, r2, r1, r0, vec};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic push_random(input logic [CNT_W-1:0] cnt, input logic last);
    push_word(pick_word(), pick_word(), pick_word(), pick_word(), pick_word(), cnt, last);
  endtask

  // Stop sending and wait for every awaited sums word to come out
  task automatic drain_sums();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sums_pending != 0) @(posedge clk_i);
  endtask

  // Mode change only with the block idle: drained, pipeline settled
  task automatic set_weight_mode(input logic [1:0] mode);
    drain_sums();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= mode;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    int         sent;
    int         quota;
    int         run_len;
    logic [1:0] mode;

    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b1;
    idle_en       = 1'b1;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: 8 bit weights straight from reset
    push_word(32'h7F7F_7F7F, 32'h7F7F_7F7F, 32'h8080_8080, 32'h7F7F_7F7F,
              32'h8080_8080, 3'd4, 1'b0);
    push_word(32'h8080_8080, 32'h8080_8080, 32'h7F7F_7F7F, 32'h0102_0304,
              32'hFFFF_FFFF, 3'd4, 1'b1);
    // zero count: nothing added, sums still emitted
    push_word($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), 3'd0, 1'b1);
    // count above four clamps to four
    push_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF, 3'd7, 1'b1);
    push_word(32'h0000_0080, 32'h0000_007F, 32'h0000_0080, 32'h0000_00FF,
              32'h0000_0001, 3'd1, 1'b0);
    push_word($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), 3'd5, 1'b1);

    // 4 bit weights; upper half of each row word is ignored
    set_weight_mode(WMODE_INT4);
    push_word(32'h8080_8080, 32'h8888_8888, 32'h7777_7777, 32'hFFFF_FFFF,
              32'h1234_5678, 3'd4, 1'b1);
    push_word(32'h7F7F_7F7F, 32'h7777_7777, 32'h8888_8888, 32'h0F0F_0F0F,
              32'hF0F0_F0F0, 3'd3, 1'b0);
    push_word($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), 3'd6, 1'b1);

    // 2 bit weights
    set_weight_mode(WMODE_INT2);
    push_word(32'h8080_8080, 32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF,
              32'h0000_00E4, 3'd4, 1'b1);
    push_word(32'h7F7F_7F7F, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_001B,
              32'hFFFF_0000, 3'd2, 1'b0);
    push_word($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), 3'd4, 1'b1);

    // spare mode code falls back to 8 bit
    set_weight_mode(WMODE_SPARE);
    push_word(32'h8080_8080, 32'h8080_8080, 32'h7F7F_7F7F, 32'hFFFF_FFFF,
              32'h0000_0000, 3'd4, 1'b1);
    push_word($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), 3'd7, 1'b1);

    // Random: one mode per phase, runs of words closed by a last word
    sent = 0;
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       mode = WMODE_INT8;
        1:       mode = WMODE_INT4;
        2:       mode = WMODE_INT2;
        3:       mode = WMODE_SPARE;
        default: mode = 2'($urandom_range(0, 3));
      endcase
      set_weight_mode(mode);
      if (p == PHASES - 1) idle_en = 1'b0;   // closing stretch runs flat out
      quota = RANDOM_WORDS * (p + 1) / PHASES;
      while (sent < quota) begin
        run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40)
                                              : $urandom_range(1, 8);
        for (int k = 0; k < run_len; k++) begin
          push_random(pick_count(), k == run_len - 1);
          sent++;
          // once, mid-run: sender holds off until all sums are out
          if (p == 1 && sent == quota - 70) drain_sums();
        end
      end
    end

    drain_sums();
    repeat (SETTLE_CYCLES * 2) @(posedge clk_i);
    if (sum_errors == 0 && sums_pending == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
